// ===== rtl/core/shmd_pkg.sv =====
// ----------------------------------------------------------------------------
// shmd_pkg
// Shared types, sizes and helpers of the sync-header message deframer queue.
// ----------------------------------------------------------------------------
package shmd_pkg;

    // Ring geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int SLOT_BYTES  = 256;
    localparam int STORE_SIZE  = QUEUE_DEPTH * SLOT_BYTES;

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int OFF_W   = $clog2(SLOT_BYTES);
    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 8;

    // Result stream data: out_byte, answer_length, queue_count, zero fill.
    localparam int OUT_DATA_W = ((2 * BYTE_W + COUNT_W + 7) / 8) * 8;

    // Configuration register indexes and reset values.
    localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hF0;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

    // Header byte positions.
    localparam logic [2:0] HDR_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] HDR_SYNC_SECOND = 3'd1;
    localparam logic [2:0] HDR_LENGTH      = 3'd2;
    localparam logic [2:0] HDR_REPLY       = 3'd3;
    localparam logic [2:0] HDR_ADDRESS     = 3'd4;

    // Request kinds carried on the input tuser.
    localparam logic MODE_HOST_BYTE = 1'b0;
    localparam logic MODE_READ      = 1'b1;

    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_REJECT  = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_DROPPED = 3'd3,
        ST_READ    = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_EXEC = 2'd1,
        CTL_OUT  = 2'd2
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [OFF_W-1:0]  off);
        return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
    endfunction

endpackage

// ===== rtl/core/shmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// shmd_ctrl
// Sequencer that takes one request, lets the datapath execute it and holds
// the result until the consumer takes it.
// ----------------------------------------------------------------------------
module shmd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output shmd_pkg::ctl_cmd_t cmd
);
    import shmd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = CTL_OUT;
            end
            CTL_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/shmd_datapath.sv =====
// ----------------------------------------------------------------------------
// shmd_datapath
// Header collection, slot ring storage, queue pointers and result register.
// ----------------------------------------------------------------------------
module shmd_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  shmd_pkg::ctl_cmd_t            cmd,
    input  logic                          in_mode,
    input  logic [shmd_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    output shmd_pkg::status_t             res_status,
    output logic [shmd_pkg::BYTE_W-1:0]   res_byte,
    output logic                          res_last,
    output logic [shmd_pkg::LEN_W-1:0]    res_answer,
    output logic [shmd_pkg::COUNT_W-1:0]  res_count
);
    import shmd_pkg::*;

    // Configuration.
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    // Captured request.
    logic              mode_reg;
    logic [BYTE_W-1:0] byte_reg;

    // Deframer and queue state.
    logic               in_payload_reg,     in_payload_next;
    logic [2:0]         header_index_reg,   header_index_next;
    logic               sync_good_reg,      sync_good_next;
    logic [LEN_W-1:0]   payload_length_reg, payload_length_next;
    logic [LEN_W-1:0]   reply_length_reg,   reply_length_next;
    logic [LEN_W-1:0]   payload_index_reg,  payload_index_next;
    logic               drop_reg,           drop_next;
    logic [SLOT_W-1:0]  head_slot_reg,      head_slot_next;
    logic [SLOT_W-1:0]  tail_slot_reg,      tail_slot_next;
    logic [COUNT_W-1:0] count_reg,          count_next;
    logic [LEN_W-1:0]   read_offset_reg,    read_offset_next;

    // Result register.
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] obyte_reg,  obyte_next;
    logic              last_reg,   last_next;
    logic [LEN_W-1:0]  answer_reg, answer_next;

    // Slot byte store and per-slot lengths {reply, payload}.
    logic [BYTE_W-1:0]        store_mem [STORE_SIZE];
    logic [2*LEN_W-1:0]       len_mem   [QUEUE_DEPTH];
    logic [BYTE_W-1:0]        store_rd_reg;
    logic [2*LEN_W-1:0]       len_rd_reg;
    logic                     store_we;
    logic [ADDR_W-1:0]        store_waddr;
    logic [ADDR_W-1:0]        store_raddr;
    logic                     len_we;

    logic [LEN_W-1:0] pi_inc;
    logic [LEN_W:0]   ro_inc;
    logic             hdr_reject;

    assign store_raddr = slot_addr(head_slot_reg, read_offset_reg[OFF_W-1:0]);
    assign store_waddr = slot_addr(tail_slot_reg, payload_index_reg[OFF_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= byte_reg;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[tail_slot_reg] <= {reply_length_reg, payload_length_reg};
        end
        len_rd_reg <= len_mem[head_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            byte_reg <= in_byte;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            obyte_reg  <= obyte_next;
            last_reg   <= last_next;
            answer_reg <= answer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg     <= 1'b0;
            header_index_reg   <= HDR_SYNC_FIRST;
            sync_good_reg      <= 1'b1;
            payload_length_reg <= '0;
            reply_length_reg   <= '0;
            payload_index_reg  <= '0;
            drop_reg           <= 1'b0;
            head_slot_reg      <= '0;
            tail_slot_reg      <= '0;
            count_reg          <= '0;
            read_offset_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            in_payload_reg     <= in_payload_next;
            header_index_reg   <= header_index_next;
            sync_good_reg      <= sync_good_next;
            payload_length_reg <= payload_length_next;
            reply_length_reg   <= reply_length_next;
            payload_index_reg  <= payload_index_next;
            drop_reg           <= drop_next;
            head_slot_reg      <= head_slot_next;
            tail_slot_reg      <= tail_slot_next;
            count_reg          <= count_next;
            read_offset_reg    <= read_offset_next;
        end
    end

    assign pi_inc     = payload_index_reg + LEN_W'(1);
    assign ro_inc     = {1'b0, read_offset_reg} + (LEN_W + 1)'(1);
    assign hdr_reject = !sync_good_reg || (payload_length_reg == '0) ||
                        ({1'b0, payload_length_reg} > (LEN_W + 1)'(SLOT_BYTES));

    always_comb
    begin
        in_payload_next     = in_payload_reg;
        header_index_next   = header_index_reg;
        sync_good_next      = sync_good_reg;
        payload_length_next = payload_length_reg;
        reply_length_next   = reply_length_reg;
        payload_index_next  = payload_index_reg;
        drop_next           = drop_reg;
        head_slot_next      = head_slot_reg;
        tail_slot_next      = tail_slot_reg;
        count_next          = count_reg;
        read_offset_next    = read_offset_reg;
        status_next         = ST_TAKEN;
        obyte_next          = '0;
        last_next           = 1'b0;
        answer_next         = '0;
        store_we            = 1'b0;
        len_we              = 1'b0;

        if (mode_reg == MODE_HOST_BYTE)
        begin
            if (!in_payload_reg)
            begin
                case (header_index_reg)
                    HDR_SYNC_FIRST:
                    begin
                        if (byte_reg != sync_first_reg)
                        begin
                            sync_good_next = 1'b0;
                        end
                    end
                    HDR_SYNC_SECOND:
                    begin
                        if (byte_reg != sync_second_reg)
                        begin
                            sync_good_next = 1'b0;
                        end
                    end
                    HDR_LENGTH:  payload_length_next = byte_reg;
                    HDR_REPLY:   reply_length_next   = byte_reg;
                    default:     ;
                endcase
                if (header_index_reg < HDR_ADDRESS)
                begin
                    header_index_next = header_index_reg + 3'd1;
                end
                else
                begin
                    // Address byte closes the header.
                    header_index_next = HDR_SYNC_FIRST;
                    sync_good_next    = 1'b1;
                    if (hdr_reject)
                    begin
                        status_next = ST_REJECT;
                    end
                    else
                    begin
                        in_payload_next    = 1'b1;
                        payload_index_next = '0;
                        drop_next          = (count_reg >= COUNT_W'(QUEUE_DEPTH));
                    end
                end
            end
            else
            begin
                store_we = cmd.execute && !drop_reg;
                if (pi_inc < payload_length_reg)
                begin
                    payload_index_next = pi_inc;
                end
                else
                begin
                    in_payload_next    = 1'b0;
                    payload_index_next = '0;
                    if (drop_reg)
                    begin
                        drop_next   = 1'b0;
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        len_we         = cmd.execute;
                        tail_slot_next = next_slot(tail_slot_reg);
                        count_next     = count_reg + COUNT_W'(1);
                        status_next    = ST_QUEUED;
                    end
                end
            end
        end
        else if (count_reg == '0)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_READ;
            obyte_next  = store_rd_reg;
            answer_next = len_rd_reg[2*LEN_W-1:LEN_W];
            if (ro_inc >= {1'b0, len_rd_reg[LEN_W-1:0]})
            begin
                last_next        = 1'b1;
                read_offset_next = '0;
                head_slot_next   = next_slot(head_slot_reg);
                count_next       = count_reg - COUNT_W'(1);
            end
            else
            begin
                read_offset_next = ro_inc[LEN_W-1:0];
            end
        end
    end

    assign res_status = status_reg;
    assign res_byte   = obyte_reg;
    assign res_last   = last_reg;
    assign res_answer = answer_reg;
    assign res_count  = count_reg;

endmodule

// ===== rtl/core/sync_header_message_deframer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sync_header_message_deframer_queue_top
// Deframes sync-header messages from a host byte stream into a slot ring and
// returns queued messages byte by byte on read requests.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted, executed in the next cycle, and its result
// is presented on the cycle after that.
// Requests: a new request is accepted only once the consumer has taken the
// previous result; the sequencer steps through accept, execute and present.
// Reset: rst_n clears the sequencer, the queue pointers and the sync registers
// (0xF0, 0xAA) at once; the slot memories are not cleared and need no sweep.
module sync_header_message_deframer_queue_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    input  logic                            s_axis_tuser,  // [0] mode
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_byte, [15:8] answer_length, then queue_count, zero fill above.
    output logic [shmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // [2:0] status
    output logic                            m_axis_tlast,  // out_last
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);
    import shmd_pkg::*;

    ctl_cmd_t           cmd;
    status_t            res_status;
    logic [BYTE_W-1:0]  res_byte;
    logic               res_last;
    logic [LEN_W-1:0]   res_answer;
    logic [COUNT_W-1:0] res_count;

    // Configuration is taken at any time; the user writes it only while idle.
    assign cfg_ready = 1'b1;

    // The sequencer accepts one request, lets the datapath execute it in its
    // execute state and then holds the result until the consumer takes it.
    shmd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // The datapath keeps the header collector, the slot ring with its byte
    // store and length table, and the result register.
    shmd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_mode    (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_status (res_status),
        .res_byte   (res_byte),
        .res_last   (res_last),
        .res_answer (res_answer),
        .res_count  (res_count)
    );

    assign m_axis_tdata = OUT_DATA_W'({res_count, res_answer, res_byte});
    assign m_axis_tuser = res_status;
    assign m_axis_tlast = res_last;

`ifndef SYNTHESIS
    // Only one request is ever in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while a result is pending");

    // The queue never holds more messages than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond ring depth");

    // Only a read result can mark the last byte of a message.
    a_last_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ST_READ))
        else $error("last flag on a non-read result");

    // An accepted request produces a result after the sequencer's execute state.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("result missing after accepted request");
`endif

endmodule
